@@ rtl/ptcc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptcc_pkg
// Types, constants and codes shared by the text cell compositor modules.
// ----------------------------------------------------------------------------
package ptcc_pkg;

   // frame store geometry
   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 64;
   localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   // in-range positions fit these widths (both limits are at most 256)
   localparam int POS_W  = 8;
   localparam int LIM_W  = POS_W + 1;
   localparam int IDX_W  = 2 * POS_W + 1;

   localparam logic [7:0]         BLANK_GLYPH    = 8'd32;
   localparam logic [15:0]        BLANK_COLOR    = 16'd0;
   localparam logic signed [15:0] EMPTY_PRIORITY = -16'sd1;

   // operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // register indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] row;
      logic signed [15:0] column;
      logic [7:0]         glyph;
      logic [15:0]        color;
      logic signed [15:0] draw_order;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  cell_glyph;
      logic [15:0] cell_color;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]         glyph;
      logic [15:0]        color;
      logic signed [15:0] prio;
   } cell_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take the input item, read its cell
      logic sweep;     // write blank cell at sweep address, advance
      logic commit;    // draw: compare priority, write if allowed
      logic load_rsp;  // read: load the output register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
   } dp_stat_type;

endpackage

@@ rtl/priority_text_cell_compositor.sv @@
// ----------------------------------------------------------------------------
// priority_text_cell_compositor
// Character-cell frame store with a per-cell priority, drawn and read one
// cell per item.
// ----------------------------------------------------------------------------
// A draw item reads its cell in the accepting cycle, then compares priority
// and writes in ST_DRAW on the one memory port pair. A read item reads its
// cell in the accepting cycle and loads the output register in ST_READ,
// which waits while the previous result is held in the output register;
// unused operation codes leave the block in ST_IDLE. A clear item walks
// the whole store after the accepting cycle, one cell per cycle, during
// which no item is accepted. The same clearing pass runs after reset, so
// req_stall stays high for the whole pass. Screen size registers may be
// written at any time the block is idle, including during that pass.
module priority_text_cell_compositor
   import ptcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ptcc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_item.operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   ptcc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTHESIS
   a_sweep_excludes_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sweep && cmd.commit))
      else $error("clear sweep and draw commit at once");

   a_draw_commits: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_item.operation == OP_DRAW) |=> cmd.commit)
      else $error("accepted draw item not committed next cycle");

   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_item.operation == OP_CLEAR)
         |=> (cmd.sweep && req_stall))
      else $error("accepted clear item did not start sweep");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("loaded result not shown");
`endif

endmodule

@@ rtl/ptcc_dp.sv @@
// ----------------------------------------------------------------------------
// ptcc_dp
// Datapath: screen size registers, position check, cell memory with
// read-compare-write, clear sweep counter and output register.
// ----------------------------------------------------------------------------
module ptcc_dp
   import ptcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata,
   input  req_item_type req_item,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   output rsp_item_type rsp_item
);

   logic [7:0] screen_width_ff;
   logic [6:0] screen_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= 8'd80;
         screen_height_ff <= 7'd25;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // effective limits, clamped to the store size
   logic [LIM_W-1:0] w_eff;
   logic [LIM_W-1:0] h_eff;
   assign w_eff = (LIM_W'(screen_width_ff) > LIM_W'(MAX_COLUMNS)) ?
                  LIM_W'(MAX_COLUMNS) : LIM_W'(screen_width_ff);
   assign h_eff = (LIM_W'(screen_height_ff) > LIM_W'(MAX_ROWS)) ?
                  LIM_W'(MAX_ROWS) : LIM_W'(screen_height_ff);

   logic row_ok, col_ok, in_range;
   assign row_ok   = !req_item.row[15] && (req_item.row[14:0] < 15'(h_eff));
   assign col_ok   = !req_item.column[15] && (req_item.column[14:0] < 15'(w_eff));
   assign in_range = row_ok && col_ok;

   logic [IDX_W-1:0]  idx_full;
   logic [ADDR_W-1:0] raddr;
   assign idx_full = IDX_W'(req_item.row[POS_W-1:0]) * IDX_W'(MAX_COLUMNS)
                   + IDX_W'(req_item.column[POS_W-1:0]);
   assign raddr    = idx_full[ADDR_W-1:0];

   // captured item
   logic [ADDR_W-1:0]  addr_ff;
   logic               in_range_ff;
   cell_type           draw_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff       <= raddr;
         in_range_ff   <= in_range;
         draw_ff.glyph <= req_item.glyph;
         draw_ff.color <= req_item.color;
         draw_ff.prio  <= req_item.draw_order;
      end
   end

   // clear sweep counter
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   assign stat.sweep_last = (sweep_ff == ADDR_W'(CELL_COUNT - 1));

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep) begin
         sweep_in = stat.sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   // cell memory
   cell_type          cell_mem_ff [CELL_COUNT];
   cell_type          rd_ff;
   cell_type          wdata;
   logic [ADDR_W-1:0] waddr;
   logic              wr_en;
   logic              draw_ok;

   // stored priority above the draw hides it; ties overwrite
   assign draw_ok = in_range_ff && !(rd_ff.prio > draw_ff.prio);

   always_comb begin
      if (cmd.sweep) begin
         waddr       = sweep_ff;
         wdata.glyph = BLANK_GLYPH;
         wdata.color = BLANK_COLOR;
         wdata.prio  = EMPTY_PRIORITY;
      end else begin
         waddr = addr_ff;
         wdata = draw_ff;
      end
   end

   assign wr_en = cmd.sweep || (cmd.commit && draw_ok);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= cell_mem_ff[raddr];
      end
   end

   // output register; off-screen reads give a blank cell
   rsp_item_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.cell_glyph <= in_range_ff ? rd_ff.glyph : BLANK_GLYPH;
         rsp_ff.cell_color <= in_range_ff ? rd_ff.color : BLANK_COLOR;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

@@ rtl/ptcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptcc_ctrl
// Controller: sequences clear sweeps, draws and reads, and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module ptcc_ctrl
   import ptcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_operation,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRAW,
      ST_READ
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.capture  = accept;
      cmd.sweep    = (state_ff == ST_CLEAR);
      cmd.commit   = (state_ff == ST_DRAW);
      cmd.load_rsp = (state_ff == ST_READ) && rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_DRAW:  state_in = ST_DRAW;
                  OP_READ:  state_in = ST_READ;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_DRAW: state_in = ST_IDLE;
         ST_READ: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ tb/priority_text_cell_compositor_test.sv @@
// ----------------------------------------------------------------------------
// priority_text_cell_compositor_test
// Self-checking bench for the text cell compositor. A directed table covers
// reset contents, screen edges, priority ties and hiding, unused opcodes and
// clear. Randomized phases follow, one per screen size setting. Read results
// are checked against the cell-level frame model here or a typed table answer.
// ----------------------------------------------------------------------------
module priority_text_cell_compositor_test
   import ptcc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 12;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int NUM_PHASES      = 8;
   // one clear pass plus the longest stalls and gaps, taken four times over
   localparam int IDLE_LIMIT      = 4 * (CELL_COUNT + 200);
   localparam int PRINT_LIMIT     = 200;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam rsp_item_type BLANK_CELL = '{cell_glyph: BLANK_GLYPH, cell_color: BLANK_COLOR};

   // screen settings per phase; height data carries bit 7 in two of them
   localparam logic [7:0] PHASE_WIDTH [NUM_PHASES] =
      '{8'd128, 8'd255, 8'd0, 8'd90, 8'd1, 8'd37, 8'd129, 8'd100};
   localparam logic [7:0] PHASE_HEIGHT [NUM_PHASES] =
      '{8'd64, 8'd255, 8'd20, 8'd0, 8'd1, 8'd13, 8'd65, 8'h96};

   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type answer;
   } table_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_SCREEN_WIDTH;
   logic [7:0]   csr_wdata = '0;

   // frame store model
   logic [7:0]         glyph_mem [CELL_COUNT];
   logic [15:0]        color_mem [CELL_COUNT];
   logic signed [15:0] prio_mem  [CELL_COUNT];
   int                 width_cfg  = 80;
   int                 height_cfg = 25;

   rsp_item_type  expected_cells [$];
   table_row_type stimulus_table [$];
   int            error_count = 0;
   int            calm_items = 0;
   logic signed [15:0] last_draw_row = '0;
   logic signed [15:0] last_draw_col = '0;

   priority_text_cell_compositor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic report(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("%0t ERROR: %s", $realtime, msg);
      end
   endtask

   function automatic bit locate_cell(input logic signed [15:0] r,
                                      input logic signed [15:0] c,
                                      output int unsigned slot);
      int w;
      int h;
      w = (width_cfg > MAX_COLUMNS) ? MAX_COLUMNS : width_cfg;
      h = (height_cfg > MAX_ROWS) ? MAX_ROWS : height_cfg;
      slot = 0;
      if (r < 0 || c < 0 || int'(r) >= h || int'(c) >= w) begin
         return 1'b0;
      end
      slot = int'(r) * MAX_COLUMNS + int'(c);
      return slot < CELL_COUNT;
   endfunction

   function automatic void blank_frame();
      foreach (glyph_mem[i]) begin
         glyph_mem[i] = BLANK_GLYPH;
         color_mem[i] = BLANK_COLOR;
         prio_mem[i]  = EMPTY_PRIORITY;
      end
   endfunction

   // apply one accepted item to the model; a read queues the cell it returns
   function automatic void composite_item(input req_item_type it, input bit typed,
                                          input rsp_item_type typed_cell);
      int unsigned  slot;
      bit           on_screen;
      rsp_item_type seen;
      on_screen = locate_cell(it.row, it.column, slot);
      case (it.operation)
         OP_CLEAR: blank_frame();
         OP_DRAW: begin
            if (on_screen && !(prio_mem[slot] > it.draw_order)) begin
               glyph_mem[slot] = it.glyph;
               color_mem[slot] = it.color;
               prio_mem[slot]  = it.draw_order;
            end
         end
         OP_READ: begin
            seen = on_screen ? rsp_item_type'{cell_glyph: glyph_mem[slot],
                                              cell_color: color_mem[slot]}
                             : BLANK_CELL;
            expected_cells.push_back(typed ? typed_cell : seen);
         end
         default: ;
      endcase
   endfunction

   function automatic void add_row(input logic [1:0] op, input int r, input int c,
                                   input int g, input int attr, input int order,
                                   input bit typed = 1'b0,
                                   input rsp_item_type want_cell = '0);
      table_row_type t;
      t.item.operation  = op;
      t.item.row        = 16'(r);
      t.item.column     = 16'(c);
      t.item.glyph      = 8'(g);
      t.item.color      = 16'(attr);
      t.item.draw_order = 16'(order);
      t.typed           = typed;
      t.answer          = want_cell;
      stimulus_table.push_back(t);
   endfunction

   // mostly near the screen edges and a small hot corner, so draws collide
   function automatic logic signed [15:0] pick_coord(input int eff, input int raw,
                                                     input int full);
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return 16'(eff);
         2:       return 16'(eff - 1);
         3:       return 16'(raw - 1);
         4:       return 16'($urandom_range(0, 3) - 2);
         5, 6:    return 16'($urandom_range(0, 3));
         default: return 16'($urandom_range(0, (eff > 0) ? eff - 1 : full - 1));
      endcase
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int unsigned  r;
      int           w_eff;
      int           h_eff;
      w_eff = (width_cfg > MAX_COLUMNS) ? MAX_COLUMNS : width_cfg;
      h_eff = (height_cfg > MAX_ROWS) ? MAX_ROWS : height_cfg;
      it.row    = pick_coord(h_eff, height_cfg, MAX_ROWS);
      it.column = pick_coord(w_eff, width_cfg, MAX_COLUMNS);
      it.glyph  = 8'($urandom);
      it.color  = 16'($urandom);
      r = $urandom_range(0, 9);
      if (r < 5) begin
         it.draw_order = 16'($urandom_range(0, 6) - 3);
      end else if (r < 9) begin
         it.draw_order = 16'($urandom);
      end else begin
         it.draw_order = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      r = $urandom_range(0, 999);
      if (r < 6) begin
         it.operation = OP_CLEAR;
      end else if (r < 520) begin
         it.operation = OP_DRAW;
         last_draw_row = it.row;
         last_draw_col = it.column;
      end else begin
         it.operation = OP_READ;
         if ($urandom_range(0, 2) == 0) begin
            it.row    = last_draw_row;
            it.column = last_draw_col;
         end
      end
      return it;
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      if (calm_items > 0) begin
         calm_items--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_items = $urandom_range(30, 80);
         return 0;
      end
      if (r < 6) return $urandom_range(15, 40);
      if (r < 25) return $urandom_range(1, 3);
      return 0;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input req_item_type it, input bit typed = 1'b0,
                            input rsp_item_type want_cell = '0);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      composite_item(it, typed, want_cell);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cells.size() == 0) begin
            report($sformatf("unexpected result %02h/%04h",
                             rsp_item.cell_glyph, rsp_item.cell_color));
         end else begin
            want = expected_cells.pop_front();
            if (rsp_item.cell_glyph !== want.cell_glyph) begin
               report($sformatf("cell_glyph %02h, expected %02h",
                                rsp_item.cell_glyph, want.cell_glyph));
            end
            if (rsp_item.cell_color !== want.cell_color) begin
               report($sformatf("cell_color %04h, expected %04h",
                                rsp_item.cell_color, want.cell_color));
            end
         end
      end
   end

   // receiver back-pressure: quiet stretches, short stalls, a few long ones
   initial begin : rsp_backpressure
      int hold;
      int quiet;
      int unsigned r;
      hold  = 0;
      quiet = 0;
      forever begin
         @(negedge clock);
         if (hold == 0 && quiet > 0) begin
            quiet--;
         end else if (hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 3) quiet = $urandom_range(100, 300);
            else if (r < 6) hold = $urandom_range(20, 60);
            else if (r < 30) hold = $urandom_range(1, 3);
         end
         rsp_stall <= (hold != 0);
         if (hold != 0) hold--;
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      req_item_type it;
      int           sent;
      blank_frame();

      // reset screen is 80 x 25
      add_row(OP_READ,  0,  0,   0,   0, 0, 1'b1, BLANK_CELL);
      add_row(OP_READ, 24, 79,   0,   0, 0, 1'b1, BLANK_CELL);
      add_row(OP_DRAW,  0,  0, 8'h41, 16'h1234, 0);
      add_row(OP_READ,  0,  0,   0,   0, 0);
      add_row(OP_DRAW,  0,  0, 8'h42, 16'h5678, -1);       // hidden by stored 0
      add_row(OP_DRAW,  0,  0, 8'h43, 16'h9abc, 0);        // tie, later draw wins
      add_row(OP_READ,  0,  0,   0,   0, 0);
      add_row(OP_DRAW, 24, 79, 255, 16'hffff, 32767);
      add_row(OP_DRAW, 24, 79,   0, 16'h0000, 32767);      // glyph zero on a tie
      add_row(OP_READ, 24, 79,   0,   0, 0);
      add_row(OP_DRAW, 25,  0, 8'h44, 16'h1111, 32767);
      add_row(OP_DRAW,  0, 80, 8'h45, 16'h2222, 32767);
      add_row(OP_DRAW, -1,  5, 8'h46, 16'h3333, 32767);
      add_row(OP_DRAW,  5, -32768, 8'h47, 16'h4444, 32767);
      add_row(OP_DRAW, 32767, 32767, 8'h48, 16'h5555, 32767);
      add_row(OP_DRAW, -32768, -32768, 8'h49, 16'h6666, 32767);
      add_row(OP_READ, 25,  0, 255, 16'hffff, -1, 1'b1, BLANK_CELL);
      add_row(OP_READ,  0, 80,   0,   0, 0, 1'b1, BLANK_CELL);
      add_row(OP_READ, -32768, 32767, 0, 0, 0, 1'b1, BLANK_CELL);
      add_row(OP_DRAW,  1,  1, 8'h78, 16'h7777, -32768);   // below an empty cell
      add_row(OP_READ,  1,  1,   0,   0, 0);
      add_row(OP_UNUSED, 32767, -1, 255, 16'hffff, -1);
      add_row(OP_CLEAR, -1, -1, 255, 16'hffff, -1);
      add_row(OP_READ,  0,  0,   0,   0, 0, 1'b1, BLANK_CELL);
      add_row(OP_READ, 24, 79,   0,   0, 0, 1'b1, BLANK_CELL);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stimulus_table[i]) begin
         send_item(stimulus_table[i].item, stimulus_table[i].typed, stimulus_table[i].answer);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // each phase ends in a read, so an empty queue means the block is idle
         req_valid <= 1'b0;
         while (expected_cells.size() != 0) @(negedge clock);
         repeat (4) @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= CSR_SCREEN_WIDTH;
         csr_wdata <= PHASE_WIDTH[p];
         @(negedge clock);
         width_cfg  = PHASE_WIDTH[p];
         csr_index <= CSR_SCREEN_HEIGHT;
         csr_wdata <= PHASE_HEIGHT[p];
         @(negedge clock);
         height_cfg = PHASE_HEIGHT[p][6:0];
         csr_we    <= 1'b0;
         @(negedge clock);

         sent = 0;
         while (sent < ITEMS_PER_PHASE - 1) begin
            if ($urandom_range(0, 24) == 0) begin
               it = random_item();
               it.operation = OP_UNUSED;
               send_item(it);
            end else begin
               send_item(random_item());
               sent++;
            end
         end
         it = random_item();
         it.operation = OP_READ;
         send_item(it);
      end

      req_valid <= 1'b0;
      while (expected_cells.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/ptcc_pkg.sv
rtl/ptcc_dp.sv
rtl/ptcc_ctrl.sv
rtl/priority_text_cell_compositor.sv
tb/priority_text_cell_compositor_test.sv
